>>> sv/ahp_pkg.sv
// Shared types and constants for the allpass Hilbert IQ pair.
// Holds the allpass coefficient table, chain codes and the one-hot state types.
// No dependencies.
`default_nettype none

package ahp_pkg;

  localparam int COEF_FRAC = 30;
  localparam int COEF_W    = 31;

  // Chain codes: which cascade the shared section unit is working on
  localparam logic [1:0] CH_SIDE_I = 2'd0;
  localparam logic [1:0] CH_SIDE_Q = 2'd1;
  localparam logic [1:0] CH_MID_I  = 2'd2;

  // Pole radii, rounded to nine decimals
  localparam longint unsigned I_RADIUS9 [4] = '{
    64'd692387778, 64'd936065432, 64'd988229523, 64'd998748845
  };
  localparam longint unsigned Q_RADIUS9 [4] = '{
    64'd402192116, 64'd856171088, 64'd972290955, 64'd995288479
  };

  // Square the radius, round to nine decimals, then convert to unsigned Q1.30 (half up)
  function automatic logic [COEF_W-1:0] coef_q30(input longint unsigned r9);
    longint unsigned sq;
    longint unsigned cq;
    sq = (r9 * r9 + 64'd500000000) / 64'd1000000000;
    cq = ((sq << COEF_FRAC) + 64'd500000000) / 64'd1000000000;
    return cq[COEF_W-1:0];
  endfunction

  localparam logic [COEF_W-1:0] COEF_I [4] = '{
    coef_q30(I_RADIUS9[0]), coef_q30(I_RADIUS9[1]),
    coef_q30(I_RADIUS9[2]), coef_q30(I_RADIUS9[3])
  };
  localparam logic [COEF_W-1:0] COEF_Q [4] = '{
    coef_q30(Q_RADIUS9[0]), coef_q30(Q_RADIUS9[1]),
    coef_q30(Q_RADIUS9[2]), coef_q30(Q_RADIUS9[3])
  };

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_ISSUE = 4'b0010,
    T_WAIT  = 4'b0100,
    T_DONE  = 4'b1000
  } top_state_t;

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MLO  = 5'b00010,
    U_MHI  = 5'b00100,
    U_ACC  = 5'b01000,
    U_FIN  = 5'b10000
  } unit_state_t;

endpackage

`default_nettype wire

>>> sv/allpass_hilbert_iq_pair_top.sv
// Top level of the allpass Hilbert IQ pair: sequencer, section history and output register.
// Depends on ahp_pkg and ahp_section_unit.
//
// Usage:
//   in_tdata carries main, mid and side samples; main+side feeds an I and a Q cascade
//   of SECTIONS allpass sections, mid feeds a separate I cascade. out_tdata carries the
//   delayed I, the Q and the delayed mid I of each beat, one result beat per input beat.
//   One section unit serves all 3*SECTIONS section updates in the order side I, side Q,
//   mid I. in_tready is low from acceptance until the result of the item moves into
//   the output register, so a new item is accepted only after the last item is done.
//   A finished result sits in the output register; the next item is accepted while it
//   waits. If the receiver still stalls when the next item is done, the block holds that
//   result internally until the output register frees up.
//   Reset (synchronous, rst_n low) clears all section history, the one-sample I delays,
//   the sequencer and out_tvalid; in_tready is low while reset is asserted.
`default_nettype none

module allpass_hilbert_iq_pair_top #(
  parameter int SECTIONS    = 4,
  parameter int SAMPLE_BITS = 24,
  parameter int STATE_BITS  = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // main_sample, mid_sample, side_sample (lowest bit up), zero padded to bytes
  input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // i_out, q_out, mid_i_out (lowest bit up), zero padded to bytes
  output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]         out_tdata
);
  import ahp_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int SW    = STATE_BITS;
  localparam int XW    = (SB > SW) ? SB : SW;
  localparam int DW    = ((3*SB + 7) / 8) * 8;
  localparam int NE    = 3 * SECTIONS;
  localparam int IDXW  = $clog2(NE);
  localparam int SECW  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CW    = ((SW > SB + 1) ? SW : SB + 1) + 1;
  localparam logic signed [CW-1:0] SMAX = CW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [CW-1:0] SMIN = -SMAX - CW'(1);

  function automatic logic [SB-1:0] sat_sample(input logic signed [CW-1:0] v);
    logic [SB-1:0] r;
    if (v > SMAX) begin
      r = SB'(SMAX);
    end else if (v < SMIN) begin
      r = SB'(SMIN);
    end else begin
      r = SB'(v);
    end
    return r;
  endfunction

  top_state_t state_r, state_nxt;

  logic [IDXW-1:0]       idx_r;
  logic [SECW-1:0]       sec_r;
  logic [1:0]            chain_r;
  logic signed [XW-1:0]  x_r;
  logic signed [XW-1:0]  net_r;
  logic signed [XW-1:0]  mid_r;
  logic signed [SW-1:0]  res_r [3];
  logic signed [SW-1:0]  side_i_delay_r;
  logic signed [SW-1:0]  mid_i_delay_r;
  logic                  out_valid_r;
  logic [DW-1:0]         out_data_r;

  logic signed [XW-1:0]  x1_r [NE];
  logic signed [XW-1:0]  x2_r [NE];
  logic signed [SW-1:0]  y1_r [NE];
  logic signed [SW-1:0]  y2_r [NE];

  logic signed [SB-1:0]  main_s, mid_s, side_s;
  logic [SB-1:0]         net_in;
  logic [1:0]            cidx;
  logic [COEF_W-1:0]     coef;
  logic                  unit_start;
  logic                  unit_done;
  logic signed [SW-1:0]  unit_y;
  logic                  sec_last;
  logic                  chain_last;
  logic                  accept;
  logic                  out_free;
  logic [DW-1:0]         out_word;

  assign main_s = in_tdata[SB-1:0];
  assign mid_s  = in_tdata[2*SB-1:SB];
  assign side_s = in_tdata[3*SB-1:2*SB];
  assign net_in = sat_sample(CW'(main_s) + CW'(side_s));

  assign in_tready  = rst_n && (state_r == T_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign sec_last   = (sec_r == SECW'(SECTIONS - 1));
  assign chain_last = (chain_r == CH_MID_I);

  assign cidx = 2'(sec_r);
  assign coef = (chain_r == CH_SIDE_Q) ? COEF_Q[cidx] : COEF_I[cidx];
  assign unit_start = (state_r == T_ISSUE);

  ahp_section_unit #(
    .XW (XW),
    .SW (SW)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .x     (x_r),
    .x2    (x2_r[idx_r]),
    .y2    (y2_r[idx_r]),
    .coef  (coef),
    .done  (unit_done),
    .y     (unit_y)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE:  if (accept) state_nxt = T_ISSUE;
      T_ISSUE: state_nxt = T_WAIT;
      T_WAIT: begin
        if (unit_done) state_nxt = (sec_last && chain_last) ? T_DONE : T_ISSUE;
      end
      T_DONE:  if (out_free) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    out_word = '0;
    out_word[SB-1:0]      = sat_sample(CW'(side_i_delay_r));
    out_word[2*SB-1:SB]   = sat_sample(CW'(res_r[CH_SIDE_Q]));
    out_word[3*SB-1:2*SB] = sat_sample(CW'(mid_i_delay_r));
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= T_IDLE;
      idx_r          <= '0;
      sec_r          <= '0;
      chain_r        <= CH_SIDE_I;
      side_i_delay_r <= '0;
      mid_i_delay_r  <= '0;
      out_valid_r    <= 1'b0;
      for (int e = 0; e < NE; e++) begin
        x1_r[e] <= '0;
        x2_r[e] <= '0;
        y1_r[e] <= '0;
        y2_r[e] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == T_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          idx_r   <= '0;
          sec_r   <= '0;
          chain_r <= CH_SIDE_I;
        end
        T_WAIT: begin
          if (unit_done) begin
            // Shift the section history by one sample
            x2_r[idx_r] <= x1_r[idx_r];
            x1_r[idx_r] <= x_r;
            y2_r[idx_r] <= y1_r[idx_r];
            y1_r[idx_r] <= unit_y;
            idx_r       <= idx_r + IDXW'(1);
            if (sec_last) begin
              sec_r   <= '0;
              chain_r <= chain_r + 2'd1;
            end else begin
              sec_r <= sec_r + SECW'(1);
            end
          end
        end
        T_DONE: begin
          if (out_free) begin
            side_i_delay_r <= res_r[CH_SIDE_I];
            mid_i_delay_r  <= res_r[CH_MID_I];
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      net_r <= XW'($signed(net_in));
      mid_r <= XW'(mid_s);
      x_r   <= XW'($signed(net_in));
    end else if (state_r == T_WAIT && unit_done) begin
      if (sec_last) begin
        res_r[chain_r] <= unit_y;
        x_r <= (chain_r == CH_SIDE_I) ? net_r : mid_r;
      end else begin
        x_r <= XW'(unit_y);
      end
    end
    if (state_r == T_DONE && out_free) out_data_r <= out_word;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> sv/ahp_section_unit.sv
// Shared second-order allpass section unit: y = c*(x + y2) - x2, rounded and saturated.
// Multiplies the magnitude in two halves on one multiplier. Depends on ahp_pkg.
`default_nettype none

module ahp_section_unit #(
  parameter int XW = 32,
  parameter int SW = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [XW-1:0]      x,
  input  wire logic signed [XW-1:0]      x2,
  input  wire logic signed [SW-1:0]      y2,
  input  wire logic [ahp_pkg::COEF_W-1:0] coef,
  output logic                           done,
  output logic signed [SW-1:0]           y
);
  import ahp_pkg::*;

  localparam int MW   = XW + 1;
  localparam int H    = (MW + 1) / 2;
  localparam int PW   = H + COEF_W;
  localparam int SUMW = MW + COEF_W + 1;
  localparam int QW   = SUMW - COEF_FRAC;
  localparam int YW   = ((QW > XW) ? QW : XW) + 2;
  localparam logic signed [YW-1:0] YMAX = YW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [YW-1:0] YMIN = -YMAX - YW'(1);
  localparam logic [SUMW-1:0] ROUND_HALF = SUMW'(1) << (COEF_FRAC - 1);

  unit_state_t state_r, state_nxt;

  logic [MW-1:0]          mag_r;
  logic                   neg_r;
  logic signed [XW-1:0]   x2_r;
  logic [COEF_W-1:0]      coef_r;
  logic [PW-1:0]          prod_r;
  logic [SUMW-1:0]        acc_r;
  logic [QW-1:0]          q_r;

  logic signed [MW-1:0]   s;
  logic [MW-1:0]          mag;
  logic [SUMW-1:0]        sum;
  logic signed [YW-1:0]   qs;
  logic signed [YW-1:0]   x2s;
  logic signed [YW-1:0]   yw;

  assign s   = MW'(x) + MW'(y2);
  assign mag = s[MW-1] ? (~s + MW'(1)) : s;
  assign sum = (SUMW'(prod_r) << H) + acc_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      U_IDLE:  if (start) state_nxt = U_MLO;
      U_MLO:   state_nxt = U_MHI;
      U_MHI:   state_nxt = U_ACC;
      U_ACC:   state_nxt = U_FIN;
      U_FIN:   state_nxt = U_IDLE;
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      U_IDLE: begin
        if (start) begin
          mag_r  <= mag;
          neg_r  <= s[MW-1];
          x2_r   <= x2;
          coef_r <= coef;
        end
      end
      U_MLO: prod_r <= PW'(coef_r * mag_r[H-1:0]);
      U_MHI: begin
        acc_r  <= SUMW'(prod_r) + ROUND_HALF;
        prod_r <= PW'(coef_r * mag_r[MW-1:H]);
      end
      U_ACC:   q_r <= sum[SUMW-1:COEF_FRAC];
      default: ;
    endcase
  end

  // Restore the sign, subtract the old input and saturate to the state range
  assign qs  = YW'({1'b0, q_r});
  assign x2s = YW'(x2_r);
  assign yw  = neg_r ? -(qs + x2s) : (qs - x2s);

  always_comb begin
    if (yw > YMAX) begin
      y = SW'(YMAX);
    end else if (yw < YMIN) begin
      y = SW'(YMIN);
    end else begin
      y = SW'(yw);
    end
  end

  assign done = (state_r == U_FIN);

endmodule

`default_nettype wire

>>> sv/ahp_checker.sv
// Port-level checker for the allpass Hilbert IQ pair, bound to the top level.
// Depends on allpass_hilbert_iq_pair_top only through the bind below.
`default_nettype none

module ahp_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0] out_tdata
);

  // A stalled result beat stays and keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed under stall");

  // in_tready is low right after an input beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again straight after a beat");

  // A result cannot appear in the cycle after an input beat
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too soon after an input beat");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

endmodule

bind allpass_hilbert_iq_pair_top ahp_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ahp_checker (.*);

`default_nettype wire
